// ===== src/gab_pkg.sv =====
// Shared types and constants for the GPT A/B active-bit editor.
`timescale 1ns / 1ps

package gab_pkg;

    localparam int MAX_ENTRY_WORDS_DEF = 64;

    localparam logic [1:0] SLOT_NONE = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int ACTIVE_BIT = 47;

    localparam logic [1:0] REG_TARGET_SLOT = 2'd0;
    localparam logic [1:0] REG_EDIT_ENABLE = 2'd1;
    localparam logic [1:0] REG_ENTRY_WORDS = 2'd2;

    typedef struct packed {
        logic       target_slot;
        logic       edit_enable;
        logic [6:0] entry_words;
    } cfg_t;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
        logic        status;
        logic [1:0]  prior;
    } stream_t;

endpackage

// ===== src/gab_entry_scan.sv =====
// Entry tracker: name scan, pair test, attribute edit and held-word burst.
`timescale 1ns / 1ps

module gab_entry_scan #(
    parameter int MAX_ENTRY_WORDS = gab_pkg::MAX_ENTRY_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gab_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [63:0]      data_word,
    input  logic             last_word,
    output logic             s_valid,
    input  logic             s_ready,
    output gab_pkg::stream_t s_data
);

    localparam int PW = $clog2(MAX_ENTRY_WORDS);

    logic [PW-1:0] pos_reg;
    logic [63:0]   held_reg [10];
    logic [7:0]    chars_reg [9];
    logic [5:0]    len_reg;
    logic          ended_reg;
    logic [1:0]    found_reg;
    logic          any_reg;
    logic          burst_reg;
    logic [3:0]    bidx_reg;
    logic [3:0]    bend_reg;
    logic          blast_reg;
    logic          bstatus_reg;
    logic [1:0]    bprior_reg;

    logic [8:0]  pos9;
    logic [8:0]  size9;
    logic        acc;
    logic        in_pass;
    logic        in_hold;
    logic        in_name;
    logic        at_end;
    logic        entry_done;
    logic [3:0]  hidx;
    logic [7:0]  chars_next [9];
    logic [5:0]  len_next;
    logic        ended_next;
    logic [1:0]  slot;
    logic [63:0] attr_next;
    logic [1:0]  found_next;
    logic        any_next;

    function automatic logic [1:0] match_slot(input logic [7:0] c [9], input logic [5:0] len);
        logic [7:0] d;
        logic [3:0] blen;
        logic       hit;
        match_slot = gab_pkg::SLOT_NONE;
        if (len >= 6'd2 && len <= 6'd8) begin
            d    = c[4'(len - 6'd1)];
            blen = 4'(len - 6'd1);
            hit  = ((blen == 4'd3) && ({c[0], c[1], c[2]} == 24'("env")))
                || ((blen == 4'd3) && ({c[0], c[1], c[2]} == 24'("dtb")))
                || ((blen == 4'd5) && ({c[0], c[1], c[2], c[3], c[4]} == 40'("uboot")))
                || ((blen == 4'd6)
                    && ({c[0], c[1], c[2], c[3], c[4], c[5]} == 48'("kernel")))
                || ((blen == 4'd7)
                    && ({c[0], c[1], c[2], c[3], c[4], c[5], c[6]} == 56'("userapp")));
            if (hit && d == 8'h30)
                match_slot = 2'd0;
            else if (hit && d == 8'h31)
                match_slot = 2'd1;
        end
    endfunction

    always_comb
    begin
        logic [7:0] ch;
        pos9 = 9'(pos_reg);
        if (cfg.entry_words < 7'd16)
            size9 = 9'd16;
        else if (9'(cfg.entry_words) > 9'(MAX_ENTRY_WORDS))
            size9 = 9'(MAX_ENTRY_WORDS);
        else
            size9 = 9'(cfg.entry_words);

        in_pass    = (pos9 < 9'd6) || (pos9 > 9'd15);
        in_hold    = (pos9 >= 9'd6) && (pos9 < 9'd15);
        at_end     = (pos9 == 9'd15);
        in_name    = (pos9 >= 9'd7) && (pos9 <= 9'd15);
        hidx       = 4'(pos9 - 9'd6);
        entry_done = (pos9 + 9'd1) >= size9;

        in_ready = !burst_reg && s_ready;
        acc      = in_valid && in_ready;

        // name scan: low byte of each UTF-16 unit, stop at first zero
        chars_next = chars_reg;
        len_next   = len_reg;
        ended_next = ended_reg;
        for (int u = 0; u < 4; u++) begin
            ch = data_word[16*u +: 8];
            if (!ended_next) begin
                if (ch == 8'h00)
                    ended_next = 1'b1;
                else begin
                    if (len_next < 6'd9)
                        chars_next[len_next[3:0]] = ch;
                    if (len_next < 6'd63)
                        len_next = len_next + 6'd1;
                end
            end
        end
        slot = match_slot(chars_next, len_next);

        attr_next  = held_reg[0];
        found_next = found_reg;
        any_next   = any_reg;
        if (slot != gab_pkg::SLOT_NONE) begin
            if (found_reg == gab_pkg::SLOT_NONE && held_reg[0][gab_pkg::ACTIVE_BIT])
                found_next = slot;
            any_next = 1'b1;
            if (cfg.edit_enable)
                attr_next[gab_pkg::ACTIVE_BIT] = (slot[0] == cfg.target_slot);
        end

        if (burst_reg) begin
            s_valid        = 1'b1;
            s_data.word    = held_reg[bidx_reg];
            s_data.last    = blast_reg && (bidx_reg == bend_reg);
            s_data.status  = bstatus_reg;
            s_data.prior   = bprior_reg;
        end else begin
            s_valid        = in_valid && in_pass;
            s_data.word    = data_word;
            s_data.last    = last_word;
            s_data.status  = !any_reg;
            s_data.prior   = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= '0;
            len_reg     <= '0;
            ended_reg   <= 1'b0;
            found_reg   <= gab_pkg::SLOT_NONE;
            any_reg     <= 1'b0;
            burst_reg   <= 1'b0;
            bidx_reg    <= '0;
            bend_reg    <= '0;
            blast_reg   <= 1'b0;
            bstatus_reg <= 1'b0;
            bprior_reg  <= gab_pkg::SLOT_NONE;
        end else if (acc) begin
            // input is never accepted during a burst
            if (entry_done || last_word) begin
                pos_reg   <= '0;
                len_reg   <= '0;
                ended_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg + PW'(1);
                if (in_name) begin
                    len_reg   <= len_next;
                    ended_reg <= ended_next;
                end
            end
            if (last_word) begin
                found_reg <= gab_pkg::SLOT_NONE;
                any_reg   <= 1'b0;
            end else if (at_end) begin
                found_reg <= found_next;
                any_reg   <= any_next;
            end
            // word 15 releases the edited burst; a last word in the held span
            // flushes what is held so far, unedited
            if (at_end || (in_hold && last_word)) begin
                burst_reg   <= 1'b1;
                bidx_reg    <= '0;
                bend_reg    <= at_end ? 4'd9 : hidx;
                blast_reg   <= last_word;
                bstatus_reg <= at_end ? !any_next : !any_reg;
                bprior_reg  <= at_end ? found_next : found_reg;
            end
        end else if (burst_reg && s_ready) begin
            if (bidx_reg == bend_reg)
                burst_reg <= 1'b0;
            else
                bidx_reg <= bidx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc) begin
            if (in_hold)
                held_reg[hidx] <= data_word;
            if (at_end) begin
                held_reg[9] <= data_word;
                held_reg[0] <= attr_next;
            end
            if (in_name)
                chars_reg <= chars_next;
        end
    end

endmodule

// ===== src/gab_out_crc.sv =====
// Output register with running CRC-32 and summary fields.
`timescale 1ns / 1ps

module gab_out_crc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    output logic             s_ready,
    input  gab_pkg::stream_t s_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      out_word,
    output logic             out_last,
    output logic [31:0]      array_crc,
    output logic             status,
    output logic [1:0]       prior_active
);

    logic        valid_reg;
    logic [63:0] word_reg;
    logic        last_reg;
    logic [31:0] acrc_reg;
    logic        status_reg;
    logic [1:0]  prior_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        load;

    // reflected CRC-32, one 64-bit word, byte 0 first (pure XOR network)
    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [63:0] w);
        logic [31:0] r;
        r = c;
        for (int b = 0; b < 8; b++) begin
            r = r ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++)
                r = (r >> 1) ^ (r[0] ? gab_pkg::CRC_POLY : 32'd0);
        end
        crc_fold = r;
    endfunction

    always_comb
    begin
        s_ready  = !valid_reg || out_ready;
        load     = s_valid && s_ready;
        crc_next = crc_fold(crc_reg, s_data.word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            crc_reg    <= gab_pkg::CRC_INIT;
            last_reg   <= 1'b0;
            acrc_reg   <= '0;
            status_reg <= 1'b0;
            prior_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                last_reg  <= s_data.last;
                if (s_data.last) begin
                    acrc_reg   <= ~crc_next;
                    status_reg <= s_data.status;
                    prior_reg  <= s_data.prior;
                    crc_reg    <= gab_pkg::CRC_INIT;
                end else begin
                    acrc_reg   <= '0;
                    status_reg <= 1'b0;
                    prior_reg  <= '0;
                    crc_reg    <= crc_next;
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= s_data.word;
    end

    assign out_valid    = valid_reg;
    assign out_word     = word_reg;
    assign out_last     = last_reg;
    assign array_crc    = acrc_reg;
    assign status       = status_reg;
    assign prior_active = prior_reg;

endmodule

// ===== src/gpt_ab_active_bit_editor_top.sv =====
// Top level of the GPT A/B active-bit editor: config registers and datapath.
//
// Streams a GPT partition-entry array in as 64-bit little-endian words
// (in_valid/in_ready, data_word, last_word) and streams the edited array out
// (out_valid/out_ready, out_word, out_last, array_crc, status, prior_active).
// An APB port holds target_slot, edit_enable and entry_words at 0x0/0x4/0x8.
// Words outside entry words 6..15 pass through the output register.
// Entry words 6..14 are absorbed one per cycle unless the output stalls;
// word 15 triggers a burst of the ten held words (attribute word edited),
// during which input is stalled. The burst is driven from the held-word
// register file, one word per cycle out of the output register while it
// can take one. Otherwise a transaction is accepted every cycle while the
// output register is empty or is read out in the same cycle.
// On the final word the CRC-32 and summary are attached and the stream state
// is reset. Reset clears stream state and sets the registers to 0, 0, 16.
// A receiver stall holds the output register and backs up to in_ready.
`timescale 1ns / 1ps

module gpt_ab_active_bit_editor_top #(
    parameter int MAX_ENTRY_WORDS = gab_pkg::MAX_ENTRY_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word,
    output logic        out_last,
    output logic [31:0] array_crc,
    output logic        status,
    output logic [1:0]  prior_active
);

    gab_pkg::cfg_t    cfg_reg;
    logic             s_valid;
    logic             s_ready;
    gab_pkg::stream_t s_data;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.target_slot <= 1'b0;
            cfg_reg.edit_enable <= 1'b0;
            cfg_reg.entry_words <= 7'd16;
        end else if (wr) begin
            case (paddr[3:2])
                gab_pkg::REG_TARGET_SLOT: cfg_reg.target_slot <= pwdata[0];
                gab_pkg::REG_EDIT_ENABLE: cfg_reg.edit_enable <= pwdata[0];
                gab_pkg::REG_ENTRY_WORDS: cfg_reg.entry_words <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gab_pkg::REG_TARGET_SLOT: prdata = {31'd0, cfg_reg.target_slot};
            gab_pkg::REG_EDIT_ENABLE: prdata = {31'd0, cfg_reg.edit_enable};
            gab_pkg::REG_ENTRY_WORDS: prdata = {25'd0, cfg_reg.entry_words};
            default:                  prdata = 32'd0;
        endcase
    end

    gab_entry_scan #(
        .MAX_ENTRY_WORDS(MAX_ENTRY_WORDS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_word (data_word),
        .last_word (last_word),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data)
    );

    gab_out_crc u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word),
        .out_last     (out_last),
        .array_crc    (array_crc),
        .status       (status),
        .prior_active (prior_active)
    );

endmodule
